// ===== rtl/rcefr_pkg.sv =====
`default_nettype none
package rcefr_pkg;

  localparam int FRAME_BYTES = 10;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int CNT_W       = $clog2(FRAME_BITS + 1);
  localparam int BYTE_AW     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  localparam logic [15:0] PRE_LO_US  = 16'd2400;
  localparam logic [15:0] PRE_HI_US  = 16'd2700;
  localparam logic [15:0] SYNC_LO_US = 16'd4700;
  localparam logic [15:0] SYNC_HI_US = 16'd5000;

  localparam logic [7:0] FIRST_BYTE = 8'd164;
  localparam logic [7:0] FOLD_BYTE0 = 8'd163;
  localparam logic [3:0] FOLD_SEED  = FOLD_BYTE0[3:0] ^ FOLD_BYTE0[7:4];
  localparam logic [3:0] CHK_HIGH   = 4'b1111;

  localparam logic [15:0] RESET_RESTART_GAP = 16'd100;
  localparam logic [15:0] RESET_GLITCH      = 16'd100;
  localparam logic [15:0] RESET_HALF_MIN    = 16'd500;
  localparam logic [15:0] RESET_HALF_MAX    = 16'd800;
  localparam logic [15:0] RESET_SYNC_OFFSET = 16'd650;

  localparam logic [2:0] REG_RESTART_GAP = 3'd0;
  localparam logic [2:0] REG_GLITCH      = 3'd1;
  localparam logic [2:0] REG_HALF_MIN    = 3'd2;
  localparam logic [2:0] REG_HALF_MAX    = 3'd3;
  localparam logic [2:0] REG_SYNC_OFFSET = 3'd4;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_PRE  = 3'd1,
    M_DATA = 3'd2,
    M_PERR = 3'd3,
    M_DERR = 3'd4,
    M_DONE = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_CHECK,
    B_EMIT
  } bstate_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] interval_us;
    logic [15:0] gap_ms;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] bits_held;
    logic       byte_valid;
    logic [3:0] byte_index;
    logic [7:0] frame_byte;
    logic       checksum_ok;
    logic       last;
  } out_t;

  typedef struct packed {
    logic       frame;
    mode_t      status;
    logic [6:0] bits_held;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic ok;
  } fb_t;

  typedef struct packed {
    logic               we;
    logic [BYTE_AW-1:0] addr;
    logic [7:0]         data;
  } ram_wr_t;

  function automatic logic [3:0] fold(input logic [7:0] b);
    return b[3:0] ^ b[7:4];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rcefr_ram.sv =====
`default_nettype none
module rcefr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcefr_front.sv =====
`default_nettype none
module rcefr_front
  import rcefr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_t         item,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             cmd_push,
  output cmd_t             cmd,
  input  wire logic        cmd_full,
  input  wire fb_t         fb,
  output ram_wr_t          ram_wr
);

  logic [15:0] restart_gap_ms, glitch_us, half_min_us, half_max_us, sync_offset_us;

  mode_t            mode, mode_next;
  logic [CNT_W-1:0] bit_total, bit_total_next;
  logic             level_now, level_now_next;
  logic             half_pending, half_pending_next;
  logic             offset_pending, offset_pending_next;
  logic             busy;
  logic [7:0]       acc;

  logic        accept;
  logic [15:0] off, t;
  logic        under, active, in_pre, in_sync, in_full, in_half;
  logic        store, store_val, frame;

  assign full   = cmd_full || busy;
  assign accept = push && !full;

  // An underflowed interval lies beyond every window and is never a glitch.
  assign off     = offset_pending ? sync_offset_us : '0;
  assign under   = item.interval_us < off;
  assign t       = item.interval_us - off;
  assign active  = (mode == M_PRE || mode == M_DATA) && (under || t > glitch_us);
  assign in_pre  = !under && t > PRE_LO_US && t < PRE_HI_US;
  assign in_sync = !under && t > SYNC_LO_US && t < SYNC_HI_US;
  assign in_full = !under && {1'b0, t} > {half_min_us, 1'b0}
                          && {1'b0, t} < {half_max_us, 1'b0};
  assign in_half = !under && t > half_min_us && t < half_max_us;

  always_comb begin
    mode_next           = mode;
    bit_total_next      = bit_total;
    level_now_next      = level_now;
    half_pending_next   = half_pending;
    offset_pending_next = offset_pending;
    store               = 1'b0;
    store_val           = 1'b0;
    frame               = 1'b0;
    if (accept) begin
      if (item.kind) begin
        mode_next         = M_IDLE;
        bit_total_next    = '0;
        level_now_next    = 1'b0;
        half_pending_next = 1'b0;
      end else begin
        offset_pending_next = 1'b0;
        if (item.gap_ms > restart_gap_ms) begin
          mode_next         = M_PRE;
          bit_total_next    = '0;
          level_now_next    = 1'b0;
          half_pending_next = 1'b0;
        end else if (active) begin
          unique case (mode)
            M_PRE: begin
              if (in_pre) begin
                mode_next = M_PRE;
              end else if (in_sync) begin
                mode_next           = M_DATA;
                level_now_next      = 1'b1;
                offset_pending_next = 1'b1;
              end else begin
                mode_next = M_PERR;
              end
            end
            M_DATA: begin
              if (in_full) begin
                level_now_next = !level_now;
                store          = 1'b1;
                store_val      = !level_now;
              end else if (in_half) begin
                if (half_pending) begin
                  half_pending_next = 1'b0;
                end else begin
                  half_pending_next = 1'b1;
                  store             = 1'b1;
                  store_val         = level_now;
                end
              end else begin
                mode_next = M_DERR;
              end
            end
            default: begin
              mode_next = mode;
            end
          endcase
          if (store) begin
            bit_total_next = bit_total + CNT_W'(1);
          end
          if (store && bit_total_next == CNT_W'(FRAME_BITS)) begin
            mode_next = M_DONE;
            frame     = 1'b1;
          end
        end
      end
    end
    // Drop the count once the back end has passed the checksum.
    if (fb.done && fb.ok) begin
      bit_total_next = '0;
    end
  end

  always_comb begin
    cmd_push      = accept;
    cmd.frame     = frame;
    cmd.status    = mode_next;
    cmd.bits_held = 7'(bit_total_next);
    ram_wr.we     = accept && store && bit_total[2:0] == 3'd7;
    ram_wr.addr   = BYTE_AW'(bit_total >> 3);
    ram_wr.data   = {acc[6:0], store_val};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      bit_total      <= '0;
      level_now      <= 1'b0;
      half_pending   <= 1'b0;
      offset_pending <= 1'b0;
      busy           <= 1'b0;
      restart_gap_ms <= RESET_RESTART_GAP;
      glitch_us      <= RESET_GLITCH;
      half_min_us    <= RESET_HALF_MIN;
      half_max_us    <= RESET_HALF_MAX;
      sync_offset_us <= RESET_SYNC_OFFSET;
    end else begin
      mode           <= mode_next;
      bit_total      <= bit_total_next;
      level_now      <= level_now_next;
      half_pending   <= half_pending_next;
      offset_pending <= offset_pending_next;
      // Hold the input while the back end walks the frame store.
      if (frame) begin
        busy <= 1'b1;
      end else if (fb.done) begin
        busy <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_RESTART_GAP: restart_gap_ms <= cfg_data;
          REG_GLITCH:      glitch_us      <= cfg_data;
          REG_HALF_MIN:    half_min_us    <= cfg_data;
          REG_HALF_MAX:    half_max_us    <= cfg_data;
          REG_SYNC_OFFSET: sync_offset_us <= cfg_data;
          default:         ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store) begin
      acc <= {acc[6:0], store_val};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcefr_cmdq.sv =====
`default_nettype none
module rcefr_cmdq
  import rcefr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t din,
  output logic      full,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      valid
);

  cmd_t       slot [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_push, do_pop;

  assign full    = cnt == 2'd2;
  assign valid   = cnt != 2'd0;
  assign dout    = slot[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= !wp;
      end
      if (do_pop) begin
        rp <= !rp;
      end
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= din;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rcefr_back.sv =====
`default_nettype none
module rcefr_back
  import rcefr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire cmd_t               cmd,
  output logic                    cmd_pop,
  output logic                    ram_re,
  output logic [BYTE_AW-1:0]      ram_raddr,
  input  wire logic [7:0]         ram_rdata,
  output fb_t                     fb,
  output logic                    empty,
  input  wire logic               pop,
  output out_t                    result
);

  localparam logic [BYTE_AW-1:0] LAST_IDX = BYTE_AW'(FRAME_BYTES - 1);

  bstate_t            state, state_next;
  logic [BYTE_AW-1:0] idx;
  logic [7:0]         prev;
  logic [7:0]         chk;
  logic [3:0]         sum;
  logic               ok;

  out_t       res_q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       oq_full, res_push, res_pop;
  out_t       res;
  logic [7:0] dec;
  logic       is_last;

  assign oq_full = cnt == 2'd2;
  assign empty   = cnt == 2'd0;
  assign result  = res_q[rp];
  assign res_pop = pop && !empty;
  assign dec     = prev ^ ram_rdata;
  assign is_last = idx == LAST_IDX;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid && cmd.frame) begin
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (is_last) begin
          state_next = B_CHECK;
        end
      end
      B_CHECK: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (!oq_full && is_last) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    res_push  = 1'b0;
    res       = '0;
    fb        = '0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid && cmd.frame) begin
          cmd_pop = 1'b1;
          ram_re  = 1'b1;
        end else if (cmd_valid && !oq_full) begin
          cmd_pop       = 1'b1;
          res_push      = 1'b1;
          res.status    = cmd.status;
          res.bits_held = cmd.bits_held;
          res.last      = 1'b1;
        end
      end
      B_SCAN: begin
        if (!is_last) begin
          ram_re    = 1'b1;
          ram_raddr = idx + BYTE_AW'(1);
        end
      end
      B_CHECK: begin
        ram_re = 1'b1;
      end
      B_EMIT: begin
        if (!oq_full) begin
          res_push        = 1'b1;
          res.status      = M_DONE;
          res.bits_held   = ok ? '0 : 7'(FRAME_BITS);
          res.byte_valid  = 1'b1;
          res.byte_index  = 4'(idx);
          res.frame_byte  = (idx == '0) ? FIRST_BYTE : dec;
          res.checksum_ok = ok;
          res.last        = is_last;
          if (is_last) begin
            fb.done = 1'b1;
            fb.ok   = ok;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx + BYTE_AW'(1);
          end
        end
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      wp    <= 1'b0;
      rp    <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (res_push) begin
        wp <= !wp;
      end
      if (res_pop) begin
        rp <= !rp;
      end
      case ({res_push, res_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // First pass folds the checksum, second pass emits the unchained bytes.
  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q[wp] <= res;
    end
    unique case (state)
      B_IDLE: begin
        idx <= '0;
        sum <= FOLD_SEED;
      end
      B_SCAN: begin
        prev <= ram_rdata;
        if (idx == BYTE_AW'(1)) begin
          chk <= dec;
        end
        if (idx > BYTE_AW'(1)) begin
          sum <= sum ^ fold(dec);
        end
        if (!is_last) begin
          idx <= idx + BYTE_AW'(1);
        end
      end
      B_CHECK: begin
        ok  <= chk[7:4] == CHK_HIGH && chk[3:0] == sum;
        idx <= '0;
      end
      B_EMIT: begin
        if (!oq_full) begin
          prev <= ram_rdata;
          if (!is_last) begin
            idx <= idx + BYTE_AW'(1);
          end
        end
      end
      default: begin
        idx <= '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/rolling_code_edge_frame_receiver_core.sv =====
`default_nettype none
// Channel   Ports                              Beat taken when
// -------   --------------------------------   ---------------------
// input     push, full, item (in_t)            push && !full
// result    empty, pop, result (out_t)         pop && !empty
// config    cfg_write, cfg_index, cfg_data     cfg_write
//
// Each edge or clear beat goes through the command queue; the back end writes its
// results to the result queue, one per frame byte for a completing edge, else a single
// one. A completing edge makes the back end walk the byte store twice over its one read
// port, full held high meanwhile. Reset loads the register defaults and empties both
// queues; the byte store needs no clearing. A stalled result side backs up into full.
module rolling_code_edge_frame_receiver_core
  import rcefr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_t         item,
  output logic             empty,
  input  wire logic        pop,
  output out_t             result,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic               cmd_push, cmd_full, cmd_valid, cmd_pop;
  cmd_t               cmd_in, cmd_out;
  fb_t                fb;
  ram_wr_t            ram_wr;
  logic               ram_re;
  logic [BYTE_AW-1:0] ram_raddr;
  logic [7:0]         ram_rdata;

  rcefr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full),
    .fb        (fb),
    .ram_wr    (ram_wr)
  );

  rcefr_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .valid (cmd_valid)
  );

  rcefr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rcefr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .fb        (fb),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire
